// ===== sv/lrfs_pkg.sv =====
// Shared types, constants and the window byte function for the rectangle fill sequencer.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package lrfs_pkg;

    // Payload of one input item.
    typedef struct packed {
        logic        action;
        logic [15:0] x_first;
        logic [15:0] y_first;
        logic [15:0] x_last;
        logic [15:0] y_last;
        logic [15:0] fill_colour;
    } t_in_item;

    // Payload of one result item.
    typedef struct packed {
        logic [7:0] byte_value;
        logic       is_data;
        logic       last;
    } t_out_item;

    // Configuration registers as seen by the sequencer.
    typedef struct packed {
        logic [15:0] screen_width;
        logic [15:0] screen_height;
        logic [7:0]  column_cmd;
        logic [7:0]  row_cmd;
        logic [7:0]  memwrite_cmd;
    } t_cfg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WINDOW,
        ST_PIXELS,
        ST_RESTORE
    } t_state;

    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 16;

    localparam logic [CFG_INDEX_BITS-1:0] REG_SCREEN_WIDTH  = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SCREEN_HEIGHT = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_COLUMN_CMD    = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_ROW_CMD       = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MEMWRITE_CMD  = 3'd4;

    localparam logic [15:0] RST_SCREEN_WIDTH  = 16'd320;
    localparam logic [15:0] RST_SCREEN_HEIGHT = 16'd480;
    localparam logic [7:0]  RST_COLUMN_CMD    = 8'h2A;
    localparam logic [7:0]  RST_ROW_CMD       = 8'h2B;
    localparam logic [7:0]  RST_MEMWRITE_CMD  = 8'h2C;

    localparam logic ACT_START = 1'b0;
    localparam logic ACT_TICK  = 1'b1;

    // Positions within an eleven-byte window command group.
    localparam logic [3:0] HDR_COL_CMD = 4'd0;
    localparam logic [3:0] HDR_X0_HI   = 4'd1;
    localparam logic [3:0] HDR_X0_LO   = 4'd2;
    localparam logic [3:0] HDR_X1_HI   = 4'd3;
    localparam logic [3:0] HDR_X1_LO   = 4'd4;
    localparam logic [3:0] HDR_ROW_CMD = 4'd5;
    localparam logic [3:0] HDR_Y0_HI   = 4'd6;
    localparam logic [3:0] HDR_Y0_LO   = 4'd7;
    localparam logic [3:0] HDR_Y1_HI   = 4'd8;
    localparam logic [3:0] HDR_Y1_LO   = 4'd9;
    localparam logic [3:0] HDR_MEM_CMD = 4'd10;

    // Colour byte order within one pixel.
    localparam logic [1:0] CB_RED   = 2'd0;
    localparam logic [1:0] CB_GREEN = 2'd1;
    localparam logic [1:0] CB_BLUE  = 2'd2;

    // Returns {is_data, byte} for position k of a window command group.
    function automatic logic [8:0] window_byte(
        input logic [3:0]  k,
        input t_cfg        cfg,
        input logic [15:0] x0,
        input logic [15:0] y0,
        input logic [15:0] x1,
        input logic [15:0] y1
    );
        logic [8:0] r;
        case (k)
            HDR_COL_CMD: r = {1'b0, cfg.column_cmd};
            HDR_X0_HI:   r = {1'b1, x0[15:8]};
            HDR_X0_LO:   r = {1'b1, x0[7:0]};
            HDR_X1_HI:   r = {1'b1, x1[15:8]};
            HDR_X1_LO:   r = {1'b1, x1[7:0]};
            HDR_ROW_CMD: r = {1'b0, cfg.row_cmd};
            HDR_Y0_HI:   r = {1'b1, y0[15:8]};
            HDR_Y0_LO:   r = {1'b1, y0[7:0]};
            HDR_Y1_HI:   r = {1'b1, y1[15:8]};
            HDR_Y1_LO:   r = {1'b1, y1[7:0]};
            default:     r = {1'b0, cfg.memwrite_cmd};
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== sv/lrfs_cfg_regs.sv =====
// Configuration register file of the rectangle fill sequencer.
// Depends on lrfs_pkg for the register indexes, reset values and the t_cfg struct.
`timescale 1ns / 1ps
`default_nettype none

module lrfs_cfg_regs
    import lrfs_pkg::*;
(
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_we,
    input  wire logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0]  i_cfg_data,
    output t_cfg                           o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.screen_width  <= RST_SCREEN_WIDTH;
            r_cfg.screen_height <= RST_SCREEN_HEIGHT;
            r_cfg.column_cmd    <= RST_COLUMN_CMD;
            r_cfg.row_cmd       <= RST_ROW_CMD;
            r_cfg.memwrite_cmd  <= RST_MEMWRITE_CMD;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_SCREEN_WIDTH:  r_cfg.screen_width  <= i_cfg_data;
                REG_SCREEN_HEIGHT: r_cfg.screen_height <= i_cfg_data;
                REG_COLUMN_CMD:    r_cfg.column_cmd    <= i_cfg_data[7:0];
                REG_ROW_CMD:       r_cfg.row_cmd       <= i_cfg_data[7:0];
                REG_MEMWRITE_CMD:  r_cfg.memwrite_cmd  <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ===== sv/lrfs_seq.sv =====
// Sequencer state machine: holds the fill request and works out the byte for each tick.
// Depends on lrfs_pkg for the item structs, the state enum and window_byte().
`timescale 1ns / 1ps
`default_nettype none

module lrfs_seq
    import lrfs_pkg::*;
#(
    parameter int COORD_BITS = 16
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_cfg     i_cfg,
    input  wire logic     i_accept,
    input  wire t_in_item i_item,
    output logic          o_result_valid,
    output t_out_item     o_result
);

    t_state r_state, n_state;
    logic [3:0]            r_hdr, n_hdr;
    logic [COORD_BITS-1:0] r_col, n_col;
    logic [COORD_BITS-1:0] r_row, n_row;
    logic [1:0]            r_cb, n_cb;

    // Request payload, written by every start before it is read.
    logic [COORD_BITS-1:0] r_x0, r_y0, r_x1, r_y1;
    logic [15:0]           r_colour;

    logic                  tick;
    logic                  start;
    logic [COORD_BITS-1:0] span_w, span_h;
    logic [COORD_BITS-1:0] col_inc, row_inc;
    logic [COORD_BITS-1:0] scr_x1, scr_y1;
    logic [8:0]            win_rect, win_full;
    logic                  hdr_done;

    assign tick     = i_accept && (i_item.action == ACT_TICK);
    assign start    = i_accept && (i_item.action == ACT_START) && (r_state == ST_IDLE);
    assign span_w   = r_x1 - r_x0 + COORD_BITS'(1);
    assign span_h   = r_y1 - r_y0 + COORD_BITS'(1);
    assign col_inc  = r_col + COORD_BITS'(1);
    assign row_inc  = r_row + COORD_BITS'(1);
    assign scr_x1   = i_cfg.screen_width[COORD_BITS-1:0] - COORD_BITS'(1);
    assign scr_y1   = i_cfg.screen_height[COORD_BITS-1:0] - COORD_BITS'(1);
    assign hdr_done = (r_hdr == HDR_MEM_CMD);
    assign win_rect = window_byte(r_hdr, i_cfg, 16'(r_x0), 16'(r_y0), 16'(r_x1), 16'(r_y1));
    assign win_full = window_byte(r_hdr, i_cfg, 16'd0, 16'd0, 16'(scr_x1), 16'(scr_y1));

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (start) n_state = ST_WINDOW;
            end
            ST_WINDOW: begin
                if (tick && hdr_done) begin
                    n_state = (span_w == '0 || span_h == '0) ? ST_RESTORE : ST_PIXELS;
                end
            end
            ST_PIXELS: begin
                if (tick && r_cb == CB_BLUE && col_inc >= span_w && row_inc >= span_h) begin
                    n_state = ST_RESTORE;
                end
            end
            ST_RESTORE: begin
                if (tick && hdr_done) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Result byte for the current tick.
    always_comb begin
        o_result_valid      = tick && (r_state != ST_IDLE);
        o_result.byte_value = 8'h00;
        o_result.is_data    = 1'b0;
        o_result.last       = 1'b0;
        case (r_state)
            ST_WINDOW: begin
                o_result.byte_value = win_rect[7:0];
                o_result.is_data    = win_rect[8];
            end
            ST_PIXELS: begin
                o_result.is_data = 1'b1;
                case (r_cb)
                    CB_RED:   o_result.byte_value = {r_colour[15:11], 3'b000};
                    CB_GREEN: o_result.byte_value = {r_colour[10:5], 2'b00};
                    default:  o_result.byte_value = {r_colour[4:0], 3'b000};
                endcase
            end
            ST_RESTORE: begin
                o_result.byte_value = win_full[7:0];
                o_result.is_data    = win_full[8];
                o_result.last       = hdr_done;
            end
            default: o_result_valid = 1'b0;
        endcase
    end

    // Counter updates.
    always_comb begin
        n_hdr = r_hdr;
        n_col = r_col;
        n_row = r_row;
        n_cb  = r_cb;
        if (start) begin
            n_hdr = '0;
            n_col = '0;
            n_row = '0;
            n_cb  = CB_RED;
        end else if (tick) begin
            case (r_state)
                ST_WINDOW, ST_RESTORE: begin
                    n_hdr = hdr_done ? 4'd0 : r_hdr + 4'd1;
                    if (hdr_done) begin
                        n_col = '0;
                        n_row = '0;
                        n_cb  = CB_RED;
                    end
                end
                ST_PIXELS: begin
                    if (r_cb == CB_BLUE) begin
                        n_cb = CB_RED;
                        if (col_inc >= span_w) begin
                            n_col = '0;
                            n_row = (row_inc >= span_h) ? '0 : row_inc;
                            if (row_inc >= span_h) n_hdr = '0;
                        end else begin
                            n_col = col_inc;
                        end
                    end else begin
                        n_cb = r_cb + 2'd1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_hdr   <= '0;
            r_col   <= '0;
            r_row   <= '0;
            r_cb    <= CB_RED;
        end else begin
            r_state <= n_state;
            r_hdr   <= n_hdr;
            r_col   <= n_col;
            r_row   <= n_row;
            r_cb    <= n_cb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start) begin
            r_x0     <= i_item.x_first[COORD_BITS-1:0];
            r_y0     <= i_item.y_first[COORD_BITS-1:0];
            r_x1     <= i_item.x_last[COORD_BITS-1:0];
            r_y1     <= i_item.y_last[COORD_BITS-1:0];
            r_colour <= i_item.fill_colour;
        end
    end

endmodule

`default_nettype wire

// ===== sv/lcd_rect_fill_byte_sequencer.sv =====
// Top level of the rectangle fill byte sequencer: handshakes and the result register.
// Depends on lrfs_pkg, lrfs_cfg_regs and lrfs_seq.
//
//   Channel   Signals                                Direction  Payload
//   input     i_in_valid / o_in_ready / i_in_item    in         t_in_item
//   output    o_out_valid / i_out_ready / o_out_item out        t_out_item
//   config    i_cfg_we / i_cfg_index / i_cfg_data    in         register write
//
// Every accepted tick while busy yields a byte in the next cycle; one item per cycle.
// The only limit on rate is the single result register, which may be refilled in the
// cycle it is drained. A stalled result holds the input side off until it is taken.
// Reset is synchronous and active low; it returns the block to idle with the
// configuration registers at their default values. No clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module lcd_rect_fill_byte_sequencer
    import lrfs_pkg::*;
#(
    parameter int COORD_BITS = 16
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_valid,
    output logic                           o_in_ready,
    input  wire t_in_item                  i_in_item,
    output logic                           o_out_valid,
    input  wire logic                      i_out_ready,
    output t_out_item                      o_out_item,
    input  wire logic                      i_cfg_we,
    input  wire logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0]  i_cfg_data
);

    t_cfg      cfg;
    logic      in_accept;
    logic      seq_valid;
    t_out_item seq_result;
    logic      r_out_valid;
    t_out_item r_out_item;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_accept  = i_in_valid && o_in_ready;

    lrfs_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    lrfs_seq #(
        .COORD_BITS (COORD_BITS)
    ) u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (cfg),
        .i_accept       (in_accept),
        .i_item         (i_in_item),
        .o_result_valid (seq_valid),
        .o_result       (seq_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_out_valid <= seq_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (seq_valid) begin
            r_out_item <= seq_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // A byte produced by an accepted tick is presented in the next cycle.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        seq_valid |=> o_out_valid)
        else $error("produced byte was not presented");

    // The closing byte of a sequence is always a command byte, never data.
    a_last_is_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.last |-> !o_out_item.is_data)
        else $error("final byte flagged as data");

    // A pending result that is not taken blocks new items.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |-> !in_accept)
        else $error("item accepted over a pending result");

    // A start never yields a byte of its own.
    a_start_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && i_in_item.action == ACT_START |-> !seq_valid)
        else $error("start request produced a byte");

endmodule

`default_nettype wire

// ===== tb/sv/tb_lcd_rect_fill_byte_sequencer.sv =====
// Self-checking testbench for the rectangle fill byte sequencer: fill requests and byte
// ticks go in, the display byte stream is checked against a predictor of its own.
// Depends on lrfs_pkg and lcd_rect_fill_byte_sequencer.
`timescale 1ns / 1ps

module tb_lcd_rect_fill_byte_sequencer
    import lrfs_pkg::*;
;

    class byte_stream_scoreboard;
        logic [15:0] scr_w = RST_SCREEN_WIDTH;
        logic [15:0] scr_h = RST_SCREEN_HEIGHT;
        logic [7:0]  col_cmd = RST_COLUMN_CMD;
        logic [7:0]  row_cmd = RST_ROW_CMD;
        logic [7:0]  mem_cmd = RST_MEMWRITE_CMD;

        t_state      state = ST_IDLE;
        logic [3:0]  hdr = '0;
        logic [15:0] col_cnt = '0;
        logic [15:0] row_cnt = '0;
        logic [1:0]  cbi = CB_RED;
        logic [15:0] xf, yf, xl, yl, colour;

        t_out_item   expected_bytes[$];
        int          failures = 0;

        function void set_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
            case (idx)
                REG_SCREEN_WIDTH:  scr_w = data;
                REG_SCREEN_HEIGHT: scr_h = data;
                REG_COLUMN_CMD:    col_cmd = data[7:0];
                REG_ROW_CMD:       row_cmd = data[7:0];
                REG_MEMWRITE_CMD:  mem_cmd = data[7:0];
                default: ;
            endcase
        endfunction

        // One position of an eleven-byte window group: command, first and last column, command,
        // first and last row, memory write.
        function void window_entry(logic [3:0] pos, logic [15:0] x0, logic [15:0] y0,
                                   logic [15:0] x1, logic [15:0] y1,
                                   output logic [7:0] b, output logic d);
            d = 1'b1;
            case (pos)
                HDR_COL_CMD: begin
                    b = col_cmd;
                    d = 1'b0;
                end
                HDR_X0_HI:   b = x0[15:8];
                HDR_X0_LO:   b = x0[7:0];
                HDR_X1_HI:   b = x1[15:8];
                HDR_X1_LO:   b = x1[7:0];
                HDR_ROW_CMD: begin
                    b = row_cmd;
                    d = 1'b0;
                end
                HDR_Y0_HI:   b = y0[15:8];
                HDR_Y0_LO:   b = y0[7:0];
                HDR_Y1_HI:   b = y1[15:8];
                HDR_Y1_LO:   b = y1[7:0];
                default: begin
                    b = mem_cmd;
                    d = 1'b0;
                end
            endcase
        endfunction

        // Advances the predicted state by one accepted item. Returns 1 if the item
        // had any effect on the block.
        function bit note_item(t_in_item it);
            t_out_item   res;
            logic [15:0] w, h;
            logic [7:0]  b;
            logic        d;
            res = '0;
            if (it.action == ACT_START) begin
                if (state != ST_IDLE) return 0;
                xf = it.x_first;
                yf = it.y_first;
                xl = it.x_last;
                yl = it.y_last;
                colour = it.fill_colour;
                state = ST_WINDOW;
                hdr = '0;
                col_cnt = '0;
                row_cnt = '0;
                cbi = CB_RED;
                return 1;
            end
            if (state == ST_IDLE) return 0;
            w = xl - xf + 16'd1;
            h = yl - yf + 16'd1;
            case (state)
                ST_WINDOW: begin
                    window_entry(hdr, xf, yf, xl, yl, b, d);
                    res.byte_value = b;
                    res.is_data = d;
                    if (hdr == HDR_MEM_CMD) begin
                        hdr = '0;
                        col_cnt = '0;
                        row_cnt = '0;
                        cbi = CB_RED;
                        // An empty rectangle goes straight to the closing window reset.
                        state = (w == 16'd0 || h == 16'd0) ? ST_RESTORE : ST_PIXELS;
                    end else begin
                        hdr++;
                    end
                end
                ST_PIXELS: begin
                    res.is_data = 1'b1;
                    case (cbi)
                        CB_RED: begin
                            res.byte_value = colour[15:8] & 8'hF8;
                            cbi = CB_GREEN;
                        end
                        CB_GREEN: begin
                            res.byte_value = colour[10:3] & 8'hFC;
                            cbi = CB_BLUE;
                        end
                        default: begin
                            res.byte_value = {colour[4:0], 3'b000};
                            cbi = CB_RED;
                            col_cnt++;
                            if (col_cnt >= w) begin
                                col_cnt = '0;
                                row_cnt++;
                                if (row_cnt >= h) begin
                                    row_cnt = '0;
                                    state = ST_RESTORE;
                                    hdr = '0;
                                end
                            end
                        end
                    endcase
                end
                default: begin
                    window_entry(hdr, 16'd0, 16'd0, scr_w - 16'd1, scr_h - 16'd1, b, d);
                    res.byte_value = b;
                    res.is_data = d;
                    if (hdr == HDR_MEM_CMD) begin
                        res.last = 1'b1;
                        state = ST_IDLE;
                        hdr = '0;
                    end else begin
                        hdr++;
                    end
                end
            endcase
            expected_bytes.push_back(res);
            return 1;
        endfunction

        function void check_byte(t_out_item got);
            t_out_item want;
            if (expected_bytes.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("unexpected result: byte %02h data %b last %b",
                             got.byte_value, got.is_data, got.last);
                return;
            end
            want = expected_bytes.pop_front();
            if (got.byte_value !== want.byte_value || got.is_data !== want.is_data ||
                    got.last !== want.last) begin
                failures++;
                if (failures <= 10)
                    $display({"mismatch: expected byte %02h data %b last %b, ",
                              "got byte %02h data %b last %b"},
                             want.byte_value, want.is_data, want.last,
                             got.byte_value, got.is_data, got.last);
            end
        endfunction

        function void close_out();
            if (expected_bytes.size() != 0) begin
                failures++;
                $display("%0d expected results never arrived", expected_bytes.size());
            end
        endfunction
    endclass

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      in_valid = 1'b0;
    t_in_item                  in_item = '0;
    logic                      out_ready = 1'b0;
    logic                      cfg_we = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data = '0;
    logic                      o_in_ready;
    logic                      o_out_valid;
    t_out_item                 o_out_item;

    byte_stream_scoreboard sb = new();
    int burst_left = 0;
    int applied_items = 0;
    int item_target = 0;

    lcd_rect_fill_byte_sequencer uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // The receiver switches between always ready, random stalls and long stalls.
    int rx_mode = 0;
    int rx_span = 0;
    int rx_stall = 0;
    always @(negedge i_clk) begin
        if (rx_span == 0) begin
            rx_mode = $urandom_range(0, 2);
            rx_span = $urandom_range(20, 150);
        end else begin
            rx_span--;
        end
        if (rx_stall != 0) begin
            rx_stall--;
            out_ready <= 1'b0;
        end else begin
            case (rx_mode)
                0: out_ready <= 1'b1;
                1: out_ready <= ($urandom_range(0, 3) != 0);
                default: begin
                    if ($urandom_range(0, 9) == 0) begin
                        rx_stall = $urandom_range(1, 12);
                        out_ready <= 1'b0;
                    end else begin
                        out_ready <= 1'b1;
                    end
                end
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && out_ready === 1'b1)
            sb.check_byte(o_out_item);
    end

    function automatic t_in_item random_item(logic act);
        t_in_item it;
        it.action      = act;
        it.x_first     = 16'($urandom);
        it.y_first     = 16'($urandom);
        it.x_last      = 16'($urandom);
        it.y_last      = 16'($urandom);
        it.fill_colour = 16'($urandom);
        return it;
    endfunction

    // Items go out in bursts; valid drops only between bursts.
    task automatic send_item(t_in_item it);
        if (burst_left == 0) begin
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 200)
                                                     : $urandom_range(1, 12);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge i_clk);
        while (o_in_ready !== 1'b1) @(posedge i_clk);
        if (sb.note_item(it)) applied_items++;
        @(negedge i_clk);
        burst_left--;
        if (burst_left == 0) in_valid <= 1'b0;
    endtask

    task automatic hold_sender();
        if (burst_left != 0) begin
            burst_left = 0;
            in_valid <= 1'b0;
        end
    endtask

    task automatic wait_drained();
        hold_sender();
        while (sb.expected_bytes.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        sb.set_reg(idx, data);
        @(negedge i_clk);
    endtask

    task automatic apply_settings(logic [15:0] w, logic [15:0] h, logic [7:0] c,
                                  logic [7:0] r, logic [7:0] m);
        wait_drained();
        write_reg(REG_SCREEN_WIDTH, w);
        write_reg(REG_SCREEN_HEIGHT, h);
        write_reg(REG_COLUMN_CMD, {8'h00, c});
        write_reg(REG_ROW_CMD, {8'h00, r});
        write_reg(REG_MEMWRITE_CMD, {8'h00, m});
        cfg_we <= 1'b0;
    endtask

    // One start followed by ticks until the whole stream is out. A second start is
    // slipped in after the given number of ticks when that number is not negative.
    task automatic fill_rect(logic [15:0] x0, logic [15:0] y0, logic [15:0] x1,
                             logic [15:0] y1, logic [15:0] c, int intrude_at);
        t_in_item it;
        int       n;
        it.action      = ACT_START;
        it.x_first     = x0;
        it.y_first     = y0;
        it.x_last      = x1;
        it.y_last      = y1;
        it.fill_colour = c;
        send_item(it);
        n = 0;
        while (sb.state != ST_IDLE) begin
            if (n == intrude_at) send_item(random_item(ACT_START));
            send_item(random_item(ACT_TICK));
            n++;
        end
    endtask

    task automatic random_fill();
        logic [15:0] x0, y0, w, h;
        int          pick;
        int          intrude;
        pick = $urandom_range(0, 19);
        w = (pick == 2) ? 16'($urandom_range(4, 12)) : 16'($urandom_range(1, 3));
        h = (pick == 3) ? 16'($urandom_range(4, 8)) : 16'($urandom_range(1, 3));
        if (pick == 0) w = 16'd0;
        if (pick == 1) h = 16'd0;
        x0 = 16'($urandom);
        y0 = 16'($urandom);
        intrude = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 30) : -1;
        if ($urandom_range(0, 7) == 0) send_item(random_item(ACT_TICK));
        fill_rect(x0, y0, x0 + w - 16'd1, y0 + h - 16'd1, 16'($urandom), intrude);
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part at the reset configuration.
        send_item(random_item(ACT_TICK));
        fill_rect(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF, -1);
        // Corners at the top of the range, height wrapping through zero.
        fill_rect(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 1);
        fill_rect(16'h1234, 16'h0042, 16'h1233, 16'h0043, 16'hF800, -1);
        fill_rect(16'h0010, 16'h0000, 16'h0011, 16'hFFFF, 16'h07E0, 12);
        fill_rect(16'h00FF, 16'h7FFF, 16'h0101, 16'h8000, 16'h001F, -1);
        fill_rect(16'h8000, 16'h5555, 16'h8001, 16'h5555, 16'hA5A5, -1);
        send_item(random_item(ACT_TICK));

        for (int p = 0; p < 5; p++) begin
            case (p)
                0: apply_settings(16'd1, 16'd1, 8'h00, 8'h00, 8'h00);
                1: apply_settings(16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF);
                default: apply_settings(16'($urandom_range(1, 65535)),
                                        16'($urandom_range(1, 65535)),
                                        8'($urandom), 8'($urandom), 8'($urandom));
            endcase
            item_target = applied_items + 340;
            while (applied_items < item_target) random_fill();
        end

        hold_sender();
        while (sb.expected_bytes.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        sb.close_out();
        if (sb.failures == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
